FILE: rtl/spd_pkg.sv
package spd_pkg;

  // Delay line geometry; the address width follows the depth
  localparam int LINE_DEPTH = 131072;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int LINE_W     = 20;

  // Field and register widths
  localparam int SMP_W      = 16;
  localparam int OUT_W      = 17;
  localparam int DLY_W      = 17;
  localparam int GAIN_W     = 16;
  localparam int FB_W       = 15;
  localparam int POLE_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;

  // Read index arithmetic width: wide enough for both the address and the delay
  localparam int DIFF_W = (LINE_AW > DLY_W) ? LINE_AW : DLY_W;

  // Shared multiplier: signed A by signed B
  localparam int MA_W   = 21;
  localparam int MB_W   = 18;
  localparam int PROD_W = MA_W + MB_W;

  // Datapath widths
  localparam int X_W     = 38;  // mix sum, LSB 2^-30
  localparam int MAG_W   = 36;  // |mix| and soft clip denominator
  localparam int HALF_W  = 18;  // magnitude split for the clip product
  localparam int KACC_W  = 34;  // one partial product of the clip term
  localparam int NUM_W   = 52;  // divider numerator and full clip product
  localparam int LACC_W  = 38;  // lowpass accumulator
  localparam int SAT_W   = 24;  // input width of the line saturation
  localparam int Q_W     = 17;  // quotient bits
  localparam int DIV_STEPS = Q_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int FB_SH   = 15;
  localparam int LP_SH   = 16;
  localparam int CLIP_SH = 16;
  localparam int DIV_SH  = 15;
  localparam int CLIP_ONE_SH = 30;

  localparam logic [15:0] CLIP_K = 16'd39322;  // 0.6 in Q0.16

  // Reset values of the configuration registers
  localparam logic [DLY_W-1:0]  DELAY_LEFT_RST    = 17'd16800;
  localparam logic [DLY_W-1:0]  DELAY_RIGHT_RST   = 17'd26400;
  localparam logic [GAIN_W-1:0] DIRECT_LEVEL_RST  = 16'd19661;
  localparam logic [GAIN_W-1:0] ECHO_LEVEL_RST    = 16'd26214;
  localparam logic [FB_W-1:0]   FEEDBACK_GAIN_RST = 15'd14746;
  localparam logic [POLE_W-1:0] LOWPASS_POLE_RST  = 16'd29880;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_LEFT,
    CFG_DELAY_RIGHT,
    CFG_DIRECT_LEVEL,
    CFG_ECHO_LEVEL,
    CFG_FEEDBACK_GAIN,
    CFG_LOWPASS_POLE
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MIX_DRY,
    ST_MIX_L,
    ST_MIX_R,
    ST_KL_LO,
    ST_KL_HI,
    ST_KR_LO,
    ST_KR_HI,
    ST_FB_L,
    ST_LP_L0,
    ST_LP_L1,
    ST_FB_R,
    ST_LP_R0,
    ST_LP_R1,
    ST_LP_RY,
    ST_WRITE,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

FILE: rtl/stereo_pingpong_delay.sv
// Stereo ping-pong delay: one mono Q1.15 sample in, one stereo pair out.
// Input stream (s_axis_*): one beat per sample, tdata[15:0] is the sample.
// Output stream (m_axis_*): one beat per input beat, tdata[16:0] left and
// tdata[33:17] right, both soft clipped, LSB 2^-15.
// Config port (cfg_*): index and data, always ready; write only while idle.
// Each sample runs through a sequencer around one shared 21x18 multiplier
// (mixing, clip denominators, cross feedback and lowpass), the line
// write-back, then a 17-step restoring divider that handles both channels
// side by side, then the load of the output register. Ready stays low
// from an accept beat until the output register is loaded, so a new sample
// is taken only after the last one is through; the result then shows on
// m_axis_tvalid.
// The two delay lines are synchronous RAMs read once at accept and written
// once per sample. After reset the lines read as zero: a fill count (write
// index plus a wrapped flag) masks entries not yet written, so no clearing
// pass is needed and the block is ready right away. A stalled receiver
// holds the result in the output register; the next sample is still taken
// and processed, and holds in its last step until the register frees up.
module stereo_pingpong_delay import spd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] sample
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [16:0] out_left, [33:17] out_right, zero pad
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam logic signed [SAT_W-1:0] LINE_MAX = SAT_W'(524287);
  localparam logic signed [SAT_W-1:0] LINE_MIN = -SAT_W'(524288);

  function automatic logic signed [LINE_W-1:0] sat_line(input logic signed [SAT_W-1:0] v);
    logic signed [LINE_W-1:0] r;
    if (v > LINE_MAX) begin
      r = LINE_MAX[LINE_W-1:0];
    end else if (v < LINE_MIN) begin
      r = LINE_MIN[LINE_W-1:0];
    end else begin
      r = v[LINE_W-1:0];
    end
    return r;
  endfunction

  // Configuration registers
  logic [DLY_W-1:0]  delay_left_q, delay_right_q;
  logic [GAIN_W-1:0] direct_level_q, echo_level_q;
  logic [FB_W-1:0]   feedback_gain_q;
  logic [POLE_W-1:0] lowpass_pole_q;

  // Control state
  state_e                 state_q, state_d;
  logic [LINE_AW-1:0]     w_q, w_d;
  logic                   full_q, full_d;
  logic [DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;
  logic signed [LINE_W-1:0] fm_q, fm_d;

  // Payload
  logic signed [SMP_W-1:0]  sample_q, sample_d;
  logic signed [X_W-1:0]    xd_q, xd_d, xl_q, xl_d, xr_q, xr_d;
  logic [KACC_W-1:0]        kacc_q, kacc_d;
  logic [MAG_W-1:0]         den_l_q, den_l_d, den_r_q, den_r_d;
  logic signed [LINE_W-1:0] f_q, f_d, yl_q, yl_d, yr_q, yr_d;
  logic signed [LACC_W-1:0] lacc_q, lacc_d;
  logic [MAG_W-1:0]         rem_l_q, rem_l_d, rem_r_q, rem_r_d;
  logic [Q_W-1:0]           nlo_l_q, nlo_l_d, nlo_r_q, nlo_r_d;
  logic [OUT_W-1:0]         out_l_q, out_l_d, out_r_q, out_r_d;

  // Delay line memories
  logic signed [LINE_W-1:0] left_line  [LINE_DEPTH];
  logic signed [LINE_W-1:0] right_line [LINE_DEPTH];
  logic signed [LINE_W-1:0] rd_l_q, rd_r_q;
  logic                     rd_ok_l_q, rd_ok_r_q;
  logic                     rd_en, wr_en;
  logic [DIFF_W-1:0]        diff_l, diff_r;
  logic [LINE_AW-1:0]       rd_addr_l, rd_addr_r;
  logic signed [LINE_W-1:0] wr_l, wr_r;
  logic signed [LINE_W-1:0] dl, dr;

  // Shared multiplier and helpers
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] f_rnd;
  logic signed [LACC_W-1:0] y_rnd;
  logic signed [LINE_W-1:0] y_sat;
  logic [X_W-1:0]           abs_l, abs_r;
  logic [MAG_W-1:0]         mag_l, mag_r, mag_sel;
  logic [NUM_W-1:0]         ksum, num_l, num_r;
  logic [MAG_W:0]           sh_l, sh_r;
  logic                     qb_l, qb_r;
  logic                     in_acc;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - 2 * OUT_W)'(0), out_r_q, out_l_q};

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_left_q    <= DELAY_LEFT_RST;
      delay_right_q   <= DELAY_RIGHT_RST;
      direct_level_q  <= DIRECT_LEVEL_RST;
      echo_level_q    <= ECHO_LEVEL_RST;
      feedback_gain_q <= FEEDBACK_GAIN_RST;
      lowpass_pole_q  <= LOWPASS_POLE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DELAY_LEFT:    delay_left_q    <= cfg_data_i[DLY_W-1:0];
        CFG_DELAY_RIGHT:   delay_right_q   <= cfg_data_i[DLY_W-1:0];
        CFG_DIRECT_LEVEL:  direct_level_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_ECHO_LEVEL:    echo_level_q    <= cfg_data_i[GAIN_W-1:0];
        CFG_FEEDBACK_GAIN: feedback_gain_q <= cfg_data_i[FB_W-1:0];
        CFG_LOWPASS_POLE:  lowpass_pole_q  <= cfg_data_i[POLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read taps: write index minus delay, wrapped to the line
  assign diff_l    = DIFF_W'(w_q) - DIFF_W'(delay_left_q);
  assign diff_r    = DIFF_W'(w_q) - DIFF_W'(delay_right_q);
  assign rd_addr_l = diff_l[LINE_AW-1:0];
  assign rd_addr_r = diff_r[LINE_AW-1:0];
  assign rd_en     = in_acc;
  assign wr_en     = (state_q == ST_WRITE);
  assign wr_l      = sat_line(SAT_W'(sample_q) + SAT_W'(yl_q));
  assign wr_r      = sat_line(SAT_W'(sample_q) + SAT_W'(yr_q));

  // Entries never written since reset read as zero
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_l_q    <= left_line[rd_addr_l];
      rd_r_q    <= right_line[rd_addr_r];
      rd_ok_l_q <= full_q || (rd_addr_l < w_q);
      rd_ok_r_q <= full_q || (rd_addr_r < w_q);
    end
    if (wr_en) begin
      left_line[w_q]  <= wr_l;
      right_line[w_q] <= wr_r;
    end
  end

  assign dl = rd_ok_l_q ? rd_l_q : '0;
  assign dr = rd_ok_r_q ? rd_r_q : '0;

  // Magnitudes of both mixes
  assign abs_l = xl_q[X_W-1] ? X_W'(-xl_q) : X_W'(xl_q);
  assign abs_r = xr_q[X_W-1] ? X_W'(-xr_q) : X_W'(xr_q);
  assign mag_l = abs_l[MAG_W-1:0];
  assign mag_r = abs_r[MAG_W-1:0];
  assign mag_sel = (state_q == ST_KR_LO || state_q == ST_KR_HI) ? mag_r : mag_l;

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MIX_DRY: begin
        mul_a = MA_W'(sample_q);
        mul_b = MB_W'(direct_level_q);
      end
      ST_MIX_L: begin
        mul_a = MA_W'(dl);
        mul_b = MB_W'(echo_level_q);
      end
      ST_MIX_R: begin
        mul_a = MA_W'(dr);
        mul_b = MB_W'(echo_level_q);
      end
      ST_KL_LO, ST_KR_LO: begin
        mul_a = MA_W'(mag_sel[HALF_W-1:0]);
        mul_b = MB_W'(CLIP_K);
      end
      ST_KL_HI, ST_KR_HI: begin
        mul_a = MA_W'(mag_sel[MAG_W-1:HALF_W]);
        mul_b = MB_W'(CLIP_K);
      end
      ST_FB_L: begin
        mul_a = MA_W'(dr);
        mul_b = MB_W'(feedback_gain_q);
      end
      ST_FB_R: begin
        mul_a = MA_W'(dl);
        mul_b = MB_W'(feedback_gain_q);
      end
      ST_LP_L0, ST_LP_R0: begin
        mul_a = MA_W'(f_q);
        mul_b = MB_W'(17'h10000 - 17'(lowpass_pole_q));
      end
      ST_LP_L1, ST_LP_R1: begin
        mul_a = MA_W'(fm_q);
        mul_b = MB_W'(lowpass_pole_q);
      end
      default: ;
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Round half away from zero: add half, minus one for negative values
  assign f_rnd = prod + (PROD_W'(1) << (FB_SH - 1)) - PROD_W'(prod[PROD_W-1]);
  assign y_rnd = lacc_q + (LACC_W'(1) << (LP_SH - 1)) - LACC_W'(lacc_q[LACC_W-1]);
  assign y_sat = sat_line(SAT_W'($signed(y_rnd[LACC_W-1:LP_SH])));

  // Clip product: low partial held, high partial added at an 18-bit offset
  assign ksum = NUM_W'(kacc_q) + (NUM_W'(prod[KACC_W-1:0]) << HALF_W);

  // Divider numerators: |x|*2^15 + den/2
  assign num_l = (NUM_W'(mag_l) << DIV_SH) + NUM_W'(den_l_q >> 1);
  assign num_r = (NUM_W'(mag_r) << DIV_SH) + NUM_W'(den_r_q >> 1);

  // One restoring step per channel
  assign sh_l = {rem_l_q, nlo_l_q[Q_W-1]};
  assign sh_r = {rem_r_q, nlo_r_q[Q_W-1]};
  assign qb_l = (sh_l >= (MAG_W + 1)'(den_l_q));
  assign qb_r = (sh_r >= (MAG_W + 1)'(den_r_q));

  always_comb begin
    state_d     = state_q;
    w_d         = w_q;
    full_d      = full_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    fm_d        = fm_q;
    sample_d    = sample_q;
    xd_d        = xd_q;
    xl_d        = xl_q;
    xr_d        = xr_q;
    kacc_d      = kacc_q;
    den_l_d     = den_l_q;
    den_r_d     = den_r_q;
    f_d         = f_q;
    yl_d        = yl_q;
    yr_d        = yr_q;
    lacc_d      = lacc_q;
    rem_l_d     = rem_l_q;
    rem_r_d     = rem_r_q;
    nlo_l_d     = nlo_l_q;
    nlo_r_d     = nlo_r_q;
    out_l_d     = out_l_q;
    out_r_d     = out_r_q;

    // Drop the output beat once taken
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          sample_d = s_axis_tdata[SMP_W-1:0];
          state_d  = ST_MIX_DRY;
        end
      end
      ST_MIX_DRY: begin
        xd_d    = prod[X_W-1:0];
        state_d = ST_MIX_L;
      end
      ST_MIX_L: begin
        xl_d    = xd_q + prod[X_W-1:0];
        state_d = ST_MIX_R;
      end
      ST_MIX_R: begin
        xr_d    = xd_q + prod[X_W-1:0];
        state_d = ST_KL_LO;
      end
      ST_KL_LO: begin
        kacc_d  = prod[KACC_W-1:0];
        state_d = ST_KL_HI;
      end
      ST_KL_HI: begin
        den_l_d = (MAG_W'(1) << CLIP_ONE_SH) + ksum[NUM_W-1:CLIP_SH];
        state_d = ST_KR_LO;
      end
      ST_KR_LO: begin
        kacc_d  = prod[KACC_W-1:0];
        state_d = ST_KR_HI;
      end
      ST_KR_HI: begin
        den_r_d = (MAG_W'(1) << CLIP_ONE_SH) + ksum[NUM_W-1:CLIP_SH];
        state_d = ST_FB_L;
      end
      ST_FB_L: begin
        f_d     = f_rnd[FB_SH+LINE_W-1:FB_SH];
        state_d = ST_LP_L0;
      end
      ST_LP_L0: begin
        lacc_d  = prod[LACC_W-1:0];
        state_d = ST_LP_L1;
      end
      ST_LP_L1: begin
        lacc_d  = lacc_q + prod[LACC_W-1:0];
        state_d = ST_FB_R;
      end
      ST_FB_R: begin
        // Close the left lowpass while the right feed is scaled
        fm_d    = y_sat;
        yl_d    = y_sat;
        f_d     = f_rnd[FB_SH+LINE_W-1:FB_SH];
        state_d = ST_LP_R0;
      end
      ST_LP_R0: begin
        lacc_d  = prod[LACC_W-1:0];
        state_d = ST_LP_R1;
      end
      ST_LP_R1: begin
        lacc_d  = lacc_q + prod[LACC_W-1:0];
        state_d = ST_LP_RY;
      end
      ST_LP_RY: begin
        fm_d    = y_sat;
        yr_d    = y_sat;
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        // Lines are written this cycle; load both dividers
        w_d     = w_q + LINE_AW'(1);
        full_d  = full_q || (&w_q);
        rem_l_d = MAG_W'(num_l[NUM_W-1:Q_W]);
        rem_r_d = MAG_W'(num_r[NUM_W-1:Q_W]);
        nlo_l_d = num_l[Q_W-1:0];
        nlo_r_d = num_r[Q_W-1:0];
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_l_d = qb_l ? MAG_W'(sh_l - (MAG_W + 1)'(den_l_q)) : sh_l[MAG_W-1:0];
        rem_r_d = qb_r ? MAG_W'(sh_r - (MAG_W + 1)'(den_r_q)) : sh_r[MAG_W-1:0];
        nlo_l_d = {nlo_l_q[Q_W-2:0], qb_l};
        nlo_r_d = {nlo_r_q[Q_W-2:0], qb_r};
        cnt_d   = cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_l_d     = xl_q[X_W-1] ? OUT_W'(-nlo_l_q) : OUT_W'(nlo_l_q);
          out_r_d     = xr_q[X_W-1] ? OUT_W'(-nlo_r_q) : OUT_W'(nlo_r_q);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      w_q         <= '0;
      full_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      fm_q        <= '0;
    end else begin
      state_q     <= state_d;
      w_q         <= w_d;
      full_q      <= full_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      fm_q        <= fm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    xd_q     <= xd_d;
    xl_q     <= xl_d;
    xr_q     <= xr_d;
    kacc_q   <= kacc_d;
    den_l_q  <= den_l_d;
    den_r_q  <= den_r_d;
    f_q      <= f_d;
    yl_q     <= yl_d;
    yr_q     <= yr_d;
    lacc_q   <= lacc_d;
    rem_l_q  <= rem_l_d;
    rem_r_q  <= rem_r_d;
    nlo_l_q  <= nlo_l_d;
    nlo_r_q  <= nlo_r_d;
    out_l_q  <= out_l_d;
    out_r_q  <= out_r_d;
  end

  // An accepted beat starts the sequence on the next cycle
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_MIX_DRY)
    else $error("accepted sample did not start the sequence");

  // The write pointer moves by exactly one per line write
  a_wptr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WRITE |=> w_q == $past(w_q) + LINE_AW'(1))
    else $error("write index did not advance by one");

  // A waiting result is never overwritten
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_q && !m_axis_tready) |=> state_q == ST_DONE)
    else $error("result loaded over a pending beat");

  // The soft clip quotient stays below 2^16 on both channels
  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |-> !nlo_l_q[Q_W-1] && !nlo_r_q[Q_W-1])
    else $error("soft clip quotient out of range");

endmodule
